// ===== design/lor_to_sinogram_bin_macros.svh =====
// ----------------------------------------------------------------------------
// lor_to_sinogram_bin assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LOR_TO_SINOGRAM_BIN_MACROS_SVH
`define LOR_TO_SINOGRAM_BIN_MACROS_SVH

// same-cycle implication
`define LSB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lsb_pkg.sv =====
// ----------------------------------------------------------------------------
// lsb_pkg
// shared types, register indexes and arithmetic steps of the sinogram binner
// ----------------------------------------------------------------------------
package lsb_pkg;

  localparam int MAX_RINGS    = 128;
  localparam int MAX_CRYSTALS = 1024;

  localparam int RING_W      = 7;
  localparam int ANG_W       = 10;
  localparam int CPR_W       = 11;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_ADDR_W-1:0] REG_CPR      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPAN     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HALF     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_RD   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TANG_OFF = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TANG_CNT = 3'd5;

  typedef struct packed {
    logic [CPR_W-1:0] cpr;      // saturated crystals per ring
    logic [7:0]       span;
    logic [6:0]       hs;
    logic [6:0]       max_rd;
    logic [9:0]       t_off;
    logic [10:0]      t_cnt;
  } cfg_t;

  // one restoring remainder step, remainder below divisor <= 1024
  function automatic logic [ANG_W-1:0] rem_step(logic [ANG_W-1:0] rem, logic b,
                                                logic [CPR_W-1:0] d);
    logic [CPR_W-1:0] t;
    logic [CPR_W-1:0] t_sub;
    t     = {rem, b};
    t_sub = t - d;
    return (t >= d) ? t_sub[ANG_W-1:0] : t[ANG_W-1:0];
  endfunction

  // one restoring division step, returns {quotient bit, remainder}
  function automatic logic [8:0] div_step(logic [7:0] rem, logic b, logic [7:0] d);
    logic [8:0] t;
    logic [8:0] t_sub;
    logic       ge;
    t     = {rem, b};
    t_sub = t - {1'b0, d};
    ge    = (t >= {1'b0, d});
    return {ge, (ge ? t_sub[7:0] : t[7:0])};
  endfunction

endpackage

// ===== design/lor_to_sinogram_bin.sv =====
// ----------------------------------------------------------------------------
// lor_to_sinogram_bin
// maps a coincidence event (two ring/angle crystals) to a sinogram bin
// ----------------------------------------------------------------------------
// usage
//   in_*  : one event per request, ring_a/angle_a/ring_b/angle_b in in_tdata
//   out_* : one bin per event, valid_res in out_tuser, bin fields in out_tdata
//   cfg_* : register writes, index 0..5, taken on any edge with cfg_we high;
//           user must write only while no event is in flight (not enforced)
// pipeline: four register stages; throughput one event per cycle while
//   out_tready stays high, set by the four-stage pipeline (two stages of
//   angle remainder and span division steps, geometry stage, segment
//   sign stage)
// reset: pipeline emptied, registers back to their defaults
// stall: each stage holds while the next one is full and blocked; bubbles
//   close up, so in_tready stays high until all four stages are occupied
// ----------------------------------------------------------------------------
`include "lor_to_sinogram_bin_macros.svh"

module lor_to_sinogram_bin (
  input  logic                               clk,
  input  logic                               rst_n,
  // ring_a[6:0], angle_a[16:7], ring_b[23:17], angle_b[33:24], zero pad
  input  logic [lsb_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // segment[7:0], view[16:8], axial_pos[24:17], tang_pos[34:25], zero pad
  output logic [lsb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // valid_res[0]
  output logic                               out_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [lsb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lsb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  lsb_pkg::cfg_t cfg;

  lsb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  // stage handshake
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !s4_vld_r || out_tready;
  assign rdy3      = !s3_vld_r || rdy4;
  assign rdy2      = !s2_vld_r || rdy3;
  assign rdy1      = !s1_vld_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (rdy1) s1_vld_r <= in_tvalid;
      if (rdy2) s2_vld_r <= s1_vld_r;
      if (rdy3) s3_vld_r <= s2_vld_r;
      if (rdy4) s4_vld_r <= s3_vld_r;
    end
  end

  // ---------------- stage 1: ring math, upper remainder and division steps
  logic [lsb_pkg::RING_W-1:0] ra, rb;
  logic [9:0] aa, ab;
  assign ra = in_tdata[6:0];
  assign aa = in_tdata[16:7];
  assign rb = in_tdata[23:17];
  assign ab = in_tdata[33:24];

  logic [9:0] s1_rem_a_nxt, s1_rem_b_nxt;
  logic [6:0] s1_abs_nxt, dv;
  logic [7:0] s1_rsum_nxt, s1_drem_nxt;
  logic [3:0] s1_q_nxt;
  logic       s1_ok_nxt;
  logic [8:0] ds1;

  always_comb begin
    s1_rem_a_nxt = '0;
    s1_rem_b_nxt = '0;
    for (int i = 0; i < 5; i++) begin
      s1_rem_a_nxt = lsb_pkg::rem_step(s1_rem_a_nxt, aa[9-i], cfg.cpr);
      s1_rem_b_nxt = lsb_pkg::rem_step(s1_rem_b_nxt, ab[9-i], cfg.cpr);
    end
    s1_abs_nxt  = (ra > rb) ? ra - rb : rb - ra;
    s1_rsum_nxt = {1'b0, ra} + {1'b0, rb};
    dv          = (s1_abs_nxt > cfg.hs) ? s1_abs_nxt - cfg.hs - 7'd1 : 7'd0;
    s1_drem_nxt = '0;
    s1_q_nxt    = '0;
    for (int i = 0; i < 4; i++) begin
      ds1         = lsb_pkg::div_step(s1_drem_nxt, dv[6-i], cfg.span);
      s1_drem_nxt = ds1[7:0];
      s1_q_nxt    = {s1_q_nxt[2:0], ds1[8]};
    end
    s1_ok_nxt = (cfg.cpr != '0) &&
                ({2'b0, ra} < 9'(lsb_pkg::MAX_RINGS)) &&
                ({2'b0, rb} < 9'(lsb_pkg::MAX_RINGS)) &&
                (s1_abs_nxt <= cfg.max_rd);
  end

  logic [9:0] s1_rem_a_r, s1_rem_b_r;
  logic [4:0] s1_aa_lo_r, s1_ab_lo_r;
  logic [6:0] s1_abs_r;
  logic [7:0] s1_rsum_r, s1_drem_r;
  logic [3:0] s1_q_r;
  logic [2:0] s1_dv_lo_r;
  logic       s1_rlt_r, s1_ok_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_rem_a_r <= s1_rem_a_nxt;
      s1_rem_b_r <= s1_rem_b_nxt;
      s1_aa_lo_r <= aa[4:0];
      s1_ab_lo_r <= ab[4:0];
      s1_abs_r   <= s1_abs_nxt;
      s1_rsum_r  <= s1_rsum_nxt;
      s1_drem_r  <= s1_drem_nxt;
      s1_q_r     <= s1_q_nxt;
      s1_dv_lo_r <= dv[2:0];
      s1_rlt_r   <= (ra < rb);
      s1_ok_r    <= s1_ok_nxt;
    end
  end

  // ---------------- stage 2: lower remainder and division steps
  logic [9:0] s2_a1_nxt, s2_a2_nxt;
  logic [7:0] drem2;
  logic [6:0] s2_q_nxt;
  logic [8:0] ds2;

  always_comb begin
    s2_a1_nxt = s1_rem_a_r;
    s2_a2_nxt = s1_rem_b_r;
    for (int i = 0; i < 5; i++) begin
      s2_a1_nxt = lsb_pkg::rem_step(s2_a1_nxt, s1_aa_lo_r[4-i], cfg.cpr);
      s2_a2_nxt = lsb_pkg::rem_step(s2_a2_nxt, s1_ab_lo_r[4-i], cfg.cpr);
    end
    drem2    = s1_drem_r;
    s2_q_nxt = {s1_q_r, 3'b000};
    for (int i = 0; i < 3; i++) begin
      ds2         = lsb_pkg::div_step(drem2, s1_dv_lo_r[2-i], cfg.span);
      drem2       = ds2[7:0];
      s2_q_nxt[2-i] = ds2[8];
    end
  end

  logic [9:0] s2_a1_r, s2_a2_r;
  logic [6:0] s2_abs_r, s2_q_r;
  logic [7:0] s2_rsum_r;
  logic       s2_rlt_r, s2_ok_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_a1_r   <= s2_a1_nxt;
      s2_a2_r   <= s2_a2_nxt;
      s2_abs_r  <= s1_abs_r;
      s2_q_r    <= s2_q_nxt;
      s2_rsum_r <= s1_rsum_r;
      s2_rlt_r  <= s1_rlt_r;
      s2_ok_r   <= s1_ok_r;
    end
  end

  // ---------------- stage 3: tangential, view, axial, segment magnitude
  logic [10:0]        sum3, th3;
  logic [9:0]         half3, dang3;
  logic [11:0]        x3, vt, vt1, vt2, cpr12;
  logic signed [11:0] dh3, s3_tang_nxt;
  logic signed [12:0] win3;
  logic               s3_neg1_nxt, s3_ok_nxt;
  logic [8:0]         s3_view_nxt;
  logic [14:0]        prod3;
  logic [7:0]         diff3, s3_axial_nxt, s3_mag_nxt;
  logic               span_le1;

  always_comb begin
    sum3        = {1'b0, s2_a1_r} + {1'b0, s2_a2_r};
    half3       = cfg.cpr[10:1];
    x3          = {1'b0, cfg.cpr} + {cfg.cpr, 1'b0};
    th3         = x3[11:1];
    s3_neg1_nxt = (sum3 >= {1'b0, half3}) && (sum3 < th3);
    dang3       = (s2_a2_r > s2_a1_r) ? s2_a2_r - s2_a1_r : s2_a1_r - s2_a2_r;
    dh3         = $signed({2'b00, dang3}) - $signed({2'b00, half3});
    s3_tang_nxt = s3_neg1_nxt ? -dh3 : dh3;
    win3        = $signed({s3_tang_nxt[11], s3_tang_nxt}) + $signed({3'b000, cfg.t_off});
    s3_ok_nxt   = s2_ok_r && !win3[12] && (win3 < $signed({2'b00, cfg.t_cnt}));

    cpr12       = {1'b0, cfg.cpr};
    vt          = {1'b0, sum3} + {2'b00, half3};
    vt1         = (vt >= cpr12) ? vt - cpr12 : vt;
    vt2         = (vt1 >= cpr12) ? vt1 - cpr12 : vt1;
    s3_view_nxt = vt2[9:1];

    span_le1    = (cfg.span <= 8'd1);
    prod3       = s2_q_r * cfg.span;
    diff3       = s2_rsum_r - {1'b0, s2_abs_r};
    if (span_le1) begin
      s3_axial_nxt = {1'b0, diff3[7:1]};
      s3_mag_nxt   = {1'b0, s2_abs_r};
    end else if (s2_abs_r <= cfg.hs) begin
      s3_axial_nxt = s2_rsum_r;
      s3_mag_nxt   = '0;
    end else begin
      s3_axial_nxt = s2_rsum_r - 8'd1 - {1'b0, cfg.hs} - prod3[7:0];
      s3_mag_nxt   = {1'b0, s2_q_r} + 8'd1;
    end
  end

  logic [9:0]         s3_a1_r, s3_a2_r;
  logic signed [11:0] s3_tang_r;
  logic               s3_neg1_r, s3_neg2_r, s3_rlt_r, s3_ok_r;
  logic [8:0]         s3_view_r;
  logic [7:0]         s3_axial_r, s3_mag_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_a1_r    <= s2_a1_r;
      s3_a2_r    <= s2_a2_r;
      s3_tang_r  <= s3_tang_nxt;
      s3_neg1_r  <= s3_neg1_nxt;
      s3_neg2_r  <= !(s2_a1_r < s2_a2_r);
      s3_rlt_r   <= s2_rlt_r;
      s3_ok_r    <= s3_ok_nxt;
      s3_view_r  <= s3_view_nxt;
      s3_axial_r <= s3_axial_nxt;
      s3_mag_r   <= s3_mag_nxt;
    end
  end

  // ---------------- stage 4: segment orientation and output register
  logic signed [11:0] hf4;
  logic signed [12:0] su4, cp13, c1, c2, c1w, c2w;
  logic               seg_neg4;
  logic [7:0]         seg4;

  always_comb begin
    hf4  = s3_tang_r >>> 1;
    // shift term is sign1*sign2*u with u the negated floor half
    su4  = (s3_neg1_r ^ s3_neg2_r) ? $signed({hf4[11], hf4}) : -$signed({hf4[11], hf4});
    cp13 = $signed({2'b00, cfg.cpr});
    c1   = $signed({3'b000, s3_a1_r}) - su4;
    c2   = $signed({3'b000, s3_a2_r}) + su4;
    if (c1 < 0)          c1w = c1 + cp13;
    else if (c1 >= cp13) c1w = c1 - cp13;
    else                 c1w = c1;
    if (c2 < 0)          c2w = c2 + cp13;
    else if (c2 >= cp13) c2w = c2 - cp13;
    else                 c2w = c2;
    seg_neg4 = s3_rlt_r ^ !(c1w < c2w);
    seg4     = seg_neg4 ? 8'(-s3_mag_r) : s3_mag_r;
  end

  logic [7:0] seg_r, axial_r;
  logic [8:0] view_r;
  logic [9:0] tang_r;
  logic       vres_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      vres_r  <= s3_ok_r;
      seg_r   <= s3_ok_r ? seg4 : 8'd0;
      view_r  <= s3_ok_r ? s3_view_r : 9'd0;
      axial_r <= s3_ok_r ? s3_axial_r : 8'd0;
      tang_r  <= s3_ok_r ? s3_tang_r[9:0] : 10'd0;
    end
  end

  assign out_tvalid = s4_vld_r;
  assign out_tuser  = vres_r;
  assign out_tdata  = {5'b00000, tang_r, axial_r, view_r, seg_r};

  // checks
  `LSB_ASSERT_IMPL(a_invalid_zero, out_tvalid && !out_tuser, out_tdata == '0, "invalid bin with nonzero fields")
  `LSB_ASSERT_NEXT(a_s1_hold, s1_vld_r && !rdy2, s1_vld_r && $stable(s1_rem_a_r) && $stable(s1_abs_r), "stage 1 lost under stall")
  `LSB_ASSERT_NEXT(a_s3_hold, s3_vld_r && !rdy4, s3_vld_r && $stable(s3_tang_r) && $stable(s3_ok_r), "stage 3 lost under stall")

endmodule

// ===== design/lsb_cfg.sv =====
// ----------------------------------------------------------------------------
// lsb_cfg
// configuration register file with crystal count saturation
// ----------------------------------------------------------------------------
module lsb_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lsb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lsb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output lsb_pkg::cfg_t                    cfg
);

  logic [10:0] cpr_r;
  logic [7:0]  span_r;
  logic [6:0]  hs_r;
  logic [6:0]  max_rd_r;
  logic [9:0]  t_off_r;
  logic [10:0] t_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r    <= 11'd576;
      span_r   <= 8'd1;
      hs_r     <= 7'd0;
      max_rd_r <= 7'd127;
      t_off_r  <= 10'd128;
      t_cnt_r  <= 11'd256;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lsb_pkg::REG_CPR:      cpr_r    <= cfg_wdata[10:0];
        lsb_pkg::REG_SPAN:     span_r   <= cfg_wdata[7:0];
        lsb_pkg::REG_HALF:     hs_r     <= cfg_wdata[6:0];
        lsb_pkg::REG_MAX_RD:   max_rd_r <= cfg_wdata[6:0];
        lsb_pkg::REG_TANG_OFF: t_off_r  <= cfg_wdata[9:0];
        lsb_pkg::REG_TANG_CNT: t_cnt_r  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.cpr    = (cpr_r > 11'(lsb_pkg::MAX_CRYSTALS)) ? 11'(lsb_pkg::MAX_CRYSTALS) : cpr_r;
    cfg.span   = span_r;
    cfg.hs     = hs_r;
    cfg.max_rd = max_rd_r;
    cfg.t_off  = t_off_r;
    cfg.t_cnt  = t_cnt_r;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lor_to_sinogram_bin testbench
// drives coincidence events through the stream port under several register
// settings and random stalls on both sides, and checks every returned bin
// field by field against an in-house bin mapper or typed table rows
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_EVENTS = 92;
  localparam int DIR_ROWS     = 22;
  localparam int NUM_SETS     = 7;

  // ring_a lowest, as on in_tdata
  typedef struct packed {
    logic [9:0] angle_b;
    logic [6:0] ring_b;
    logic [9:0] angle_a;
    logic [6:0] ring_a;
  } lor_t;

  typedef struct packed {
    logic       valid_res;
    logic [7:0] segment;
    logic [8:0] view;
    logic [7:0] axial_pos;
    logic [9:0] tang_pos;
  } bin_t;

  typedef struct packed {
    logic [10:0] cpr;
    logic [7:0]  span;
    logic [6:0]  hs;
    logic [6:0]  max_rd;
    logic [9:0]  t_off;
    logic [10:0] t_cnt;
  } reg_set_t;

  typedef struct {
    int set_idx;
    int ring_a, angle_a, ring_b, angle_b;
    bit typed;
    int valid_res, segment, view, axial_pos, tang_pos;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [lsb_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [lsb_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [lsb_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [lsb_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  bin_t     pending_bins[$];
  reg_set_t live_regs;
  bit       failed = 1'b0;
  bit       steady = 1'b0;
  int       cycles = 0;

  // crystals, span, half span, max ring diff, tang offset, tang count
  reg_set_t reg_sets [0:NUM_SETS-1] = '{
    '{11'd576,  8'd1,   7'd0,   7'd127, 10'd128,  11'd256},
    '{11'd0,    8'd3,   7'd1,   7'd127, 10'd128,  11'd256},
    '{11'd2047, 8'd0,   7'd127, 7'd0,   10'd1023, 11'd2047},
    '{11'd577,  8'd255, 7'd127, 7'd127, 10'd0,    11'd1},
    '{11'd1,    8'd2,   7'd0,   7'd5,   10'd0,    11'd1},
    '{11'd2,    8'd7,   7'd3,   7'd60,  10'd512,  11'd1024},
    '{11'd1024, 8'd4,   7'd2,   7'd127, 10'd300,  11'd600}
  };

  // set, ring_a, angle_a, ring_b, angle_b, typed, valid, seg, view, axial, tang
  row_t dir_rows [0:DIR_ROWS-1] = '{
    '{0, 0,   0,    0,   0,    1, 0, 0,    0, 0, 0},
    '{0, 0,   0,    0,   288,  1, 1, 0,    0, 0, 0},
    '{0, 127, 0,    0,   288,  1, 1, 127,  0, 0, 0},
    '{0, 0,   0,    127, 288,  1, 1, -127, 0, 0, 0},
    '{0, 127, 1023, 127, 1023, 0, 0, 0,    0, 0, 0},
    '{0, 5,   100,  9,   400,  0, 0, 0,    0, 0, 0},
    '{0, 64,  575,  60,  576,  0, 0, 0,    0, 0, 0},
    '{0, 3,   700,  90,  12,   0, 0, 0,    0, 0, 0},
    '{1, 10,  20,   11,  300,  1, 0, 0,    0, 0, 0},
    '{1, 127, 1023, 0,   0,    1, 0, 0,    0, 0, 0},
    '{2, 40,  0,    40,  512,  0, 0, 0,    0, 0, 0},
    '{2, 40,  0,    41,  512,  1, 0, 0,    0, 0, 0},
    '{2, 0,   1023, 0,   0,    0, 0, 0,    0, 0, 0},
    '{3, 0,   0,    0,   288,  0, 0, 0,    0, 0, 0},
    '{3, 100, 10,   20,  300,  0, 0, 0,    0, 0, 0},
    '{3, 127, 1023, 0,   1023, 0, 0, 0,    0, 0, 0},
    '{4, 2,   5,    4,   9,    0, 0, 0,    0, 0, 0},
    '{4, 0,   0,    6,   0,    0, 0, 0,    0, 0, 0},
    '{5, 0,   0,    60,  1,    0, 0, 0,    0, 0, 0},
    '{5, 100, 1,    33,  0,    0, 0, 0,    0, 0, 0},
    '{6, 10,  200,  50,  700,  0, 0, 0,    0, 0, 0},
    '{6, 127, 3,    0,   1000, 0, 0, 0,    0, 0, 0}
  };

  lor_to_sinogram_bin dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int pos_mod(int x, int n);
    int r;
    r = x % n;
    return (r < 0) ? r + n : r;
  endfunction

  function automatic bin_t bin_of_event(lor_t ev, reg_set_t rs);
    int r1, r2, a1, a2, cpr, half, rdiff, sum, s1, s2, dang, tang, lo;
    int span, hs, axial, view, seg, u, c1, c2;
    bin_t b;
    b = '0;
    r1 = int'(ev.ring_a);
    r2 = int'(ev.ring_b);
    a1 = int'(ev.angle_a);
    a2 = int'(ev.angle_b);
    cpr = int'(rs.cpr);
    span = int'(rs.span);
    hs = int'(rs.hs);
    if (cpr > lsb_pkg::MAX_CRYSTALS) cpr = lsb_pkg::MAX_CRYSTALS;
    if (cpr == 0) return b;
    a1 = a1 % cpr;
    a2 = a2 % cpr;
    half = cpr / 2;
    rdiff = (r1 > r2) ? r1 - r2 : r2 - r1;
    if (rdiff > int'(rs.max_rd)) return b;
    sum = a1 + a2;
    s1 = (sum >= half && sum < (3 * cpr) / 2) ? -1 : 1;
    dang = (a2 > a1) ? a2 - a1 : a1 - a2;
    tang = s1 * (dang - half);
    lo = -int'(rs.t_off);
    if (tang < lo || tang >= lo + int'(rs.t_cnt)) return b;
    if (span <= 1) begin
      axial = (r1 + r2 - rdiff) / 2;
      seg = rdiff;
    end else if (rdiff <= hs) begin
      axial = r1 + r2;
      seg = 0;
    end else begin
      seg = 1 + (rdiff - hs - 1) / span;
      axial = r1 + r2 - (1 + hs + (seg - 1) * span);
    end
    view = ((sum + half) % cpr) / 2;
    if (seg != 0) begin
      s2 = (a1 < a2) ? 1 : -1;
      // negated floor of half the tangential coordinate
      u = (tang >= 0) ? -(tang / 2) : (1 - tang) / 2;
      c1 = pos_mod(a1 - s1 * s2 * u, cpr);
      c2 = pos_mod(a2 + s1 * s2 * u, cpr);
      seg = seg * ((r1 < r2) ? -1 : 1) * ((c1 < c2) ? 1 : -1);
    end
    b.valid_res = 1'b1;
    b.segment   = seg[7:0];
    b.view      = view[8:0];
    b.axial_pos = axial[7:0];
    b.tang_pos  = tang[9:0];
    return b;
  endfunction

  function automatic reg_set_t draw_setting();
    reg_set_t rs;
    int c;
    case ($urandom_range(9))
      0:       rs.cpr = 11'($urandom_range(2047));
      1:       rs.cpr = 11'(2 * $urandom_range(1, 8));
      2:       rs.cpr = 11'(2 * $urandom_range(8, 512) + 1);
      default: rs.cpr = 11'(2 * $urandom_range(8, 512));
    endcase
    rs.span = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 12));
    rs.hs = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : rs.span[7:1];
    rs.max_rd = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) :
                                           7'($urandom_range(40, 127));
    c = (rs.cpr > lsb_pkg::MAX_CRYSTALS) ? lsb_pkg::MAX_CRYSTALS : int'(rs.cpr);
    if ($urandom_range(3) == 0) begin
      rs.t_off = 10'($urandom_range(1023));
      rs.t_cnt = 11'($urandom_range(2047));
    end else begin
      rs.t_off = 10'(c / 2 - int'($urandom_range(c / 4)));
      rs.t_cnt = 11'(2 * int'(rs.t_off) + 1);
    end
    return rs;
  endfunction

  function automatic lor_t draw_lor(reg_set_t rs);
    lor_t ev;
    int c, d, rb, ra, aa, jitter;
    c = (rs.cpr > lsb_pkg::MAX_CRYSTALS) ? lsb_pkg::MAX_CRYSTALS :
        ((rs.cpr == 0) ? 1 : int'(rs.cpr));
    ra = $urandom_range(127);
    if ($urandom_range(3) != 0) begin
      d = $urandom_range(rs.max_rd);
      rb = $urandom_range(1) ? ra + d : ra - d;
      if (rb > 127) rb = 127;
      if (rb < 0) rb = 0;
    end else begin
      rb = $urandom_range(127);
    end
    ev.ring_a = 7'(ra);
    ev.ring_b = 7'(rb);
    case ($urandom_range(3))
      0: begin
        ev.angle_a = 10'($urandom_range(1023));
        ev.angle_b = 10'($urandom_range(1023));
      end
      1: begin
        ev.angle_a = 10'($urandom_range(c - 1));
        ev.angle_b = 10'($urandom_range(c - 1));
      end
      default: begin
        // roughly opposite crystals, near the center of the tangential range
        aa = $urandom_range(c - 1);
        jitter = $urandom_range(c / 2);
        ev.angle_a = 10'(aa);
        ev.angle_b = 10'((aa + c / 2 + jitter - c / 4 + c) % c);
      end
    endcase
    return ev;
  endfunction

  task automatic load_regs(input reg_set_t rs);
    logic [lsb_pkg::CFG_ADDR_W-1:0] idx;
    while (pending_bins.size() != 0) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      idx = i[lsb_pkg::CFG_ADDR_W-1:0];
      cfg_we <= 1'b1;
      cfg_addr <= idx;
      case (idx)
        lsb_pkg::REG_CPR:      cfg_wdata <= rs.cpr;
        lsb_pkg::REG_SPAN:     cfg_wdata <= {3'd0, rs.span};
        lsb_pkg::REG_HALF:     cfg_wdata <= {4'd0, rs.hs};
        lsb_pkg::REG_MAX_RD:   cfg_wdata <= {4'd0, rs.max_rd};
        lsb_pkg::REG_TANG_OFF: cfg_wdata <= {1'b0, rs.t_off};
        default:               cfg_wdata <= rs.t_cnt;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    live_regs = rs;
  endtask

  // returns once the request is taken
  task automatic send_lor(input lor_t ev);
    while (!steady && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(lsb_pkg::IN_TDATA_W - $bits(lor_t)){1'b0}}, ev};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic check_field(input string name, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    bin_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.valid_res = out_tuser;
      got.segment   = out_tdata[7:0];
      got.view      = out_tdata[16:8];
      got.axial_pos = out_tdata[24:17];
      got.tang_pos  = out_tdata[34:25];
      if (pending_bins.size() == 0) begin
        $error("result with no event pending: %h", out_tdata);
        failed = 1'b1;
      end else begin
        want = pending_bins.pop_front();
        check_field("valid_res", {15'd0, want.valid_res}, {15'd0, got.valid_res});
        check_field("segment", {{8{want.segment[7]}}, want.segment},
                    {{8{got.segment[7]}}, got.segment});
        check_field("view", {7'd0, want.view}, {7'd0, got.view});
        check_field("axial_pos", {8'd0, want.axial_pos}, {8'd0, got.axial_pos});
        check_field("tang_pos", {{6{want.tang_pos[9]}}, want.tang_pos},
                    {{6{got.tang_pos[9]}}, got.tang_pos});
      end
    end
    out_tready <= steady || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    lor_t ev;
    bin_t want;
    int cur_set;
    live_regs = reg_sets[0];
    cur_set = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].set_idx != cur_set) begin
        in_tvalid <= 1'b0;
        cur_set = dir_rows[i].set_idx;
        load_regs(reg_sets[cur_set]);
      end
      ev.ring_a  = 7'(dir_rows[i].ring_a);
      ev.angle_a = 10'(dir_rows[i].angle_a);
      ev.ring_b  = 7'(dir_rows[i].ring_b);
      ev.angle_b = 10'(dir_rows[i].angle_b);
      send_lor(ev);
      if (dir_rows[i].typed) begin
        want.valid_res = 1'(dir_rows[i].valid_res);
        want.segment   = 8'(dir_rows[i].segment);
        want.view      = 9'(dir_rows[i].view);
        want.axial_pos = 8'(dir_rows[i].axial_pos);
        want.tang_pos  = 10'(dir_rows[i].tang_pos);
      end else begin
        want = bin_of_event(ev, live_regs);
      end
      pending_bins.push_back(want);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      in_tvalid <= 1'b0;
      load_regs((p == 0) ? reg_sets[0] : draw_setting());
      // one phase with no stalls on either side
      steady = (p == 4);
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        ev = draw_lor(live_regs);
        send_lor(ev);
        pending_bins.push_back(bin_of_event(ev, live_regs));
      end
    end
    in_tvalid <= 1'b0;
    steady = 1'b0;

    while (pending_bins.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
